// ===== src/tli_pkg.sv =====
// Shared constants and types for the piecewise linear interpolation table.
package tli_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 32;
  localparam int PTR_W       = $clog2(TABLE_DEPTH);
  localparam int PIU_W       = 6;
  localparam int DATA_W      = 32;
  localparam int PROD_W      = 2 * DATA_W;

  // Stream packing widths
  localparam int IDX_W       = 5;
  localparam int S_TDATA_W   = 72;
  localparam int M_TDATA_W   = 32;

  // Input transaction kinds
  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } opcode_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_MUL,
    ST_DLOAD,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== src/tli_div.sv =====
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, 32-bit quotient.
module tli_div (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [tli_pkg::PROD_W-1:0] dividend,
  input  logic [tli_pkg::DATA_W-1:0] divisor,
  output logic                       done,
  output logic [tli_pkg::DATA_W-1:0] quotient
);
  import tli_pkg::*;

  localparam int STEP_W = $clog2(DATA_W);

  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] dvs;
  logic [STEP_W-1:0] step;
  logic              busy;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   trial;
  logic              fits;

  // One quotient bit per cycle; the upper dividend half is always below the divisor
  assign shifted = {rem, quo[DATA_W-1]};
  assign fits    = shifted >= {1'b0, dvs};
  assign trial   = shifted - {1'b0, dvs};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == STEP_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend[PROD_W-1:DATA_W];
      quo <= dividend[DATA_W-1:0];
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? trial[DATA_W-1:0] : shifted[DATA_W-1:0];
      quo <= {quo[DATA_W-2:0], fits};
    end
  end

  assign quotient = quo;

endmodule

// ===== src/table_linear_interpolator_core.sv =====
// Piecewise linear interpolation table over signed Q16.16 points, stream in and out.
// Write transaction: stored in the table when accepted, no result.
// Query: scans the x memory one entry per cycle, then setup, one multiply and a serial
// divide; a clamped result skips the multiply and the divide.
// One transaction at a time; a new one is taken once the result sits in the output register.
// Reset clears control and sets points_in_use to 32; table contents stay undefined until written.
module table_linear_interpolator_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [tli_pkg::PIU_W-1:0]     cfg_wdata,      // points_in_use
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // [4:0] point_index, [36:5] x_value, [68:37] y_value, [71:69] zero
  input  logic [tli_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tuser,        // [0] opcode
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [tli_pkg::M_TDATA_W-1:0] m_tdata,        // [31:0] interpolated_value
  output logic [1:0]                    m_tuser         // [0] below_range, [1] above_range
);
  import tli_pkg::*;

  // Input field unpack
  logic [IDX_W-1:0]  in_index;
  logic [DATA_W-1:0] in_x;
  logic [DATA_W-1:0] in_y;
  opcode_t           in_op;

  assign in_index = s_tdata[IDX_W-1:0];
  assign in_x     = s_tdata[IDX_W+DATA_W-1:IDX_W];
  assign in_y     = s_tdata[IDX_W+2*DATA_W-1:IDX_W+DATA_W];
  assign in_op    = opcode_t'(s_tuser);

  state_t state;
  state_t state_next;

  logic in_acc;
  logic out_free;
  logic out_load;
  logic div_start;
  logic div_done;
  logic [DATA_W-1:0] div_quo;

  // Configuration and table memories
  logic [PIU_W-1:0]  points_in_use;
  logic [PTR_W-1:0]  last_ptr;
  logic [DATA_W-1:0] x_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] y_mem [TABLE_DEPTH];
  logic [DATA_W-1:0] x_rd;
  logic [DATA_W-1:0] y_rd;

  // Scan and arithmetic registers
  logic [DATA_W-1:0] xi;
  logic [PTR_W-1:0]  scan_addr;
  logic [PTR_W-1:0]  rd_idx;
  logic              rd_vld;
  logic [DATA_W-1:0] prev_x;
  logic [DATA_W-1:0] prev_y;
  logic [DATA_W-1:0] cur_x;
  logic [DATA_W-1:0] cur_y;
  logic [DATA_W-1:0] op_a;
  logic [DATA_W-1:0] op_d;
  logic [DATA_W-1:0] mag;
  logic              neg;
  logic [PROD_W-1:0] prod;
  logic [DATA_W-1:0] res_val;
  logic              res_below;
  logic              res_above;

  logic hit;
  logic at_last;

  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign hit      = $signed(x_rd) >= $signed(xi);
  assign at_last  = rd_idx == last_ptr;

  // Effective last entry: zero acts as one point, large values saturate to the depth
  always_comb begin
    if (points_in_use == '0) begin
      last_ptr = '0;
    end else if (points_in_use > PIU_W'(TABLE_DEPTH)) begin
      last_ptr = PTR_W'(TABLE_DEPTH - 1);
    end else begin
      last_ptr = PTR_W'(points_in_use - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      points_in_use <= PIU_W'(TABLE_DEPTH);
    end else if (cfg_we) begin
      points_in_use <= cfg_wdata;
    end
  end

  // Table memories: write from the stream, read at the scan pointer
  always_ff @(posedge clk) begin
    if (in_acc && in_op == OP_WRITE) begin
      x_mem[in_index[PTR_W-1:0]] <= in_x;
      y_mem[in_index[PTR_W-1:0]] <= in_y;
    end
    x_rd <= x_mem[scan_addr];
    y_rd <= y_mem[scan_addr];
  end

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc && in_op == OP_QUERY) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (rd_vld) begin
          if (hit) begin
            state_next = (rd_idx == '0) ? ST_DONE : ST_SETUP;
          end else if (at_last) begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SETUP: state_next = ST_MUL;
      ST_MUL:   state_next = ST_DLOAD;
      ST_DLOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (div_done) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    s_tready  = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state)
      ST_IDLE:  s_tready  = 1'b1;
      ST_DLOAD: div_start = 1'b1;
      ST_DONE:  out_load  = out_free;
      default: ;
    endcase
  end

  // Scan pointer and read-data tag
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
      rd_idx    <= '0;
    end else if (in_acc) begin
      scan_addr <= '0;
      rd_vld    <= 1'b0;
    end else if (state == ST_SCAN) begin
      scan_addr <= scan_addr + 1'b1;
      rd_idx    <= scan_addr;
      rd_vld    <= 1'b1;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      xi <= in_x;
    end
    unique case (state)
      ST_SCAN: begin
        if (rd_vld) begin
          if (hit) begin
            cur_x     <= x_rd;
            cur_y     <= y_rd;
            res_val   <= y_rd;
            res_below <= 1'b1;
            res_above <= 1'b0;
          end else begin
            prev_x    <= x_rd;
            prev_y    <= y_rd;
            res_val   <= y_rd;
            res_below <= 1'b0;
            res_above <= 1'b1;
          end
        end
      end
      ST_SETUP: begin
        // x1 < xi <= x2 holds, so both spans are positive and fit 32 bits
        op_a <= xi - prev_x;
        op_d <= cur_x - prev_x;
        neg  <= $signed(cur_y) < $signed(prev_y);
        mag  <= ($signed(cur_y) < $signed(prev_y)) ? (prev_y - cur_y) : (cur_y - prev_y);
      end
      ST_MUL: begin
        prod <= PROD_W'(op_a) * PROD_W'(mag);
      end
      ST_DIV: begin
        if (div_done) begin
          res_val   <= neg ? (prev_y - div_quo) : (prev_y + div_quo);
          res_below <= 1'b0;
          res_above <= 1'b0;
        end
      end
      default: ;
    endcase
  end

  tli_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (op_d),
    .done     (div_done),
    .quotient (div_quo)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= res_val;
      m_tuser <= {res_above, res_below};
    end
  end

  // Checks
  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_quo_bounded: assert property (@(posedge clk) disable iff (rst)
    div_done |-> div_quo <= mag)
    else $error("quotient exceeds the y span");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
    else $error("result flagged both below and above range");

  a_done_after_scan_or_div: assert property (@(posedge clk) disable iff (rst)
    (state_next == ST_DONE && state != ST_DONE) |-> (state == ST_SCAN || state == ST_DIV))
    else $error("result phase entered from an unexpected state");

endmodule
